// ----- rtl/sfr_pkg.sv -----
// sfr_pkg: shared types, constants and status codes for the sector fixup block.
// No dependencies; imported by every module under rtl/.
`default_nettype none

package sfr_pkg;

    localparam int MAX_SECTORS      = 16;
    localparam int MAX_RECORD_BYTES = 65536;

    // byte position saturates at MAX_RECORD_BYTES + 1
    localparam int POS_W  = $clog2(MAX_RECORD_BYTES + 2);
    localparam int SEC_W  = $clog2(MAX_SECTORS + 1);
    localparam int TRL_W  = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int SEEN_W = MAX_SECTORS + 1;
    // wide enough for offset + 2 * words and for any position
    localparam int ADDR_W = ((POS_W > 16) ? POS_W : 16) + 2;
    // whole sectors in a record; at most half the record limit matters
    localparam int SCNT_W = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [POS_W-1:0] REC_LIMIT = POS_W'(MAX_RECORD_BYTES);

    // configuration register indexes
    localparam logic [1:0] CFG_SEC_BYTES    = 2'd0;
    localparam logic [1:0] CFG_ARRAY_OFFSET = 2'd1;
    localparam logic [1:0] CFG_ARRAY_WORDS  = 2'd2;

    localparam logic [15:0] SEC_BYTES_RST    = 16'd512;
    localparam logic [15:0] ARRAY_OFFSET_RST = 16'd48;
    localparam logic [15:0] ARRAY_WORDS_RST  = 16'd3;

    // status codes, lower code wins, except that an over-long record reports ERR_CAPACITY
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SIZE     = 3'd1;
    localparam logic [2:0] ERR_COUNT    = 3'd2;
    localparam logic [2:0] ERR_PAST_END = 3'd3;
    localparam logic [2:0] ERR_MISMATCH = 3'd4;
    localparam logic [2:0] ERR_LATE     = 3'd5;
    localparam logic [2:0] ERR_CAPACITY = 3'd6;

    typedef struct packed {
        logic [15:0] sec_bytes;
        logic [15:0] array_offset;
        logic [15:0] array_words;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_record;
        logic [2:0] status;
    } res_t;

    // snapshot of a finished record handed to the status unit
    typedef struct packed {
        logic [POS_W-1:0]  rec_len;
        logic              at_boundary;
        logic [SCNT_W-1:0] sectors;
        logic [2:0]        err;
    } fin_t;

endpackage

`default_nettype wire

// ----- rtl/sfr_out_fifo.sv -----
// sfr_out_fifo: small result queue between the fixup logic and the m_ channel.
// Depends on sfr_pkg (res_t, FIFO_DEPTH). Takes up to two items per cycle.
`default_nettype none

module sfr_out_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push0,
    input  sfr_pkg::res_t      push0_data,
    input  wire logic          push1,
    input  sfr_pkg::res_t      push1_data,
    output logic               room,
    output logic               out_valid,
    input  wire logic          out_ready,
    output sfr_pkg::res_t      out_data
);
    import sfr_pkg::*;

    res_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_CNT_W-1:0] n_push;
    logic [FIFO_PTR_W-1:0] wr_ptr_alt;
    res_t                  first_data;
    logic                  pop;

    // room for the two items a final byte can bring
    assign room      = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        n_push      = FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1);
        first_data  = push0 ? push0_data : push1_data;
        wr_ptr_alt  = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + n_push - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0 || push1) begin
            mem_reg[wr_ptr_reg] <= first_data;
        end
        if (push0 && push1) begin
            mem_reg[wr_ptr_alt] <= push1_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sfr_track.sv -----
// sfr_track: per-byte record tracking, array capture, trailer check and restore.
// Depends on sfr_pkg (cfg_t, res_t, fin_t, error codes).
`default_nettype none

module sfr_track (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  sfr_pkg::cfg_t      cfg,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output logic               push_valid,
    output sfr_pkg::res_t      push_res,
    output logic               fin_valid,
    output logic [7:0]         fin_byte,
    output sfr_pkg::fin_t      fin_info
);
    import sfr_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       off_reg, off_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic [SCNT_W-1:0] nsec_reg, nsec_next;
    logic [15:0]       check_reg, check_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [7:0]        held_reg, held_next;
    logic              held_valid_reg, held_valid_next;
    logic [8:0]        pend_reg, pend_next;
    logic [2:0]        err_reg, err_next;
    logic              mism_reg, mism_next;
    logic [15:0]       trl_mem [MAX_SECTORS];
    logic [15:0]       trl_q_reg;

    logic [7:0]        outgoing;
    logic [15:0]       word;
    logic [ADDR_W-1:0] p_w, off_w, end_w, rel_w;
    logic [ADDR_W-2:0] k;
    logic [SEC_W-1:0]  kk;
    logic [TRL_W-1:0]  kidx;
    logic [TRL_W-1:0]  trl_addr;
    logic              store, cap_check, cap_trl;
    logic [SEEN_W-1:0] seen_eff;
    logic [15:0]       check_eff, trl_eff;
    logic              is_trl;
    logic              has_code;
    logic [2:0]        new_code;
    logic [8:0]        new_pend;
    logic [7:0]        cur_byte;

    always_comb begin
        outgoing  = pend_reg[8] ? pend_reg[7:0] : held_reg;
        word      = {in_byte, held_reg};

        // array word capture when its high byte arrives
        p_w       = ADDR_W'(pos_reg);
        off_w     = ADDR_W'(cfg.array_offset);
        end_w     = off_w + ADDR_W'({cfg.array_words, 1'b0});
        rel_w     = p_w - off_w;
        k         = rel_w[ADDR_W-1:1];
        store     = held_valid_reg && (p_w >= off_w) && (p_w < end_w) && rel_w[0]
                    && (k <= (ADDR_W-1)'(MAX_SECTORS));
        kk        = k[SEC_W-1:0];
        kidx      = TRL_W'(kk - 1'b1);
        cap_check = store && (kk == '0);
        cap_trl   = store && (kk != '0);
        seen_eff  = seen_reg | (store ? (SEEN_W'(1) << kk) : '0);
        check_eff = cap_check ? word : check_reg;
        // forward a trailer captured in this same step
        trl_eff   = (cap_trl && kidx == sec_reg[TRL_W-1:0]) ? word : trl_q_reg;

        is_trl    = (cfg.sec_bytes >= 16'd2) && (off_reg == cfg.sec_bytes - 16'd1);

        has_code  = 1'b0;
        new_code  = ERR_NONE;
        new_pend  = '0;
        mism_next = mism_reg;
        sec_next  = sec_reg;
        off_next  = off_reg + 16'd1;

        if (is_trl) begin
            if (!mism_reg) begin
                if (sec_reg >= SEC_W'(MAX_SECTORS)) begin
                    has_code  = 1'b1;
                    new_code  = ERR_CAPACITY;
                    mism_next = 1'b1;
                end else if (!seen_eff[0] || !seen_eff[SEC_W'(sec_reg + 1'b1)]) begin
                    has_code  = 1'b1;
                    new_code  = ERR_LATE;
                    mism_next = 1'b1;
                end else if (word != check_eff) begin
                    has_code  = 1'b1;
                    new_code  = ERR_MISMATCH;
                    mism_next = 1'b1;
                end else begin
                    outgoing = trl_eff[7:0];
                    new_pend = {1'b1, trl_eff[15:8]};
                end
            end
            if (sec_reg < SEC_W'(MAX_SECTORS)) begin
                sec_next = sec_reg + 1'b1;
            end
            off_next = '0;
        end

        nsec_next = is_trl ? nsec_reg + 1'b1 : nsec_reg;

        err_next = err_reg;
        if (has_code && (err_reg == ERR_NONE || new_code < err_reg)) begin
            err_next = new_code;
        end

        pos_next   = (pos_reg <= REC_LIMIT) ? pos_reg + 1'b1 : pos_reg;
        check_next = check_eff;
        seen_next  = seen_eff;
        cur_byte   = new_pend[8] ? new_pend[7:0] : in_byte;

        held_next       = in_byte;
        held_valid_next = 1'b1;
        pend_next       = new_pend;

        // trailer store is read for the sector of the next byte
        if (!accept) begin
            trl_addr = sec_reg[TRL_W-1:0];
        end else if (in_last) begin
            trl_addr = '0;
        end else begin
            trl_addr = sec_next[TRL_W-1:0];
        end
    end

    assign push_valid = accept && held_valid_reg;
    assign push_res   = '{out_byte: outgoing, end_of_record: 1'b0, status: ERR_NONE};
    assign fin_valid  = accept && in_last;
    assign fin_byte   = cur_byte;
    assign fin_info   = '{rec_len: pos_next, at_boundary: (off_next == 16'd0),
                          sectors: nsec_next, err: err_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            off_reg        <= '0;
            sec_reg        <= '0;
            nsec_reg       <= '0;
            check_reg      <= '0;
            seen_reg       <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            pend_reg       <= '0;
            err_reg        <= ERR_NONE;
            mism_reg       <= 1'b0;
        end else if (accept) begin
            if (in_last) begin
                // record done: start the next one clean
                pos_reg        <= '0;
                off_reg        <= '0;
                sec_reg        <= '0;
                nsec_reg       <= '0;
                check_reg      <= '0;
                seen_reg       <= '0;
                held_reg       <= '0;
                held_valid_reg <= 1'b0;
                pend_reg       <= '0;
                err_reg        <= ERR_NONE;
                mism_reg       <= 1'b0;
            end else begin
                pos_reg        <= pos_next;
                off_reg        <= off_next;
                sec_reg        <= sec_next;
                nsec_reg       <= nsec_next;
                check_reg      <= check_next;
                seen_reg       <= seen_next;
                held_reg       <= held_next;
                held_valid_reg <= held_valid_next;
                pend_reg       <= pend_next;
                err_reg        <= err_next;
                mism_reg       <= mism_next;
            end
        end
    end

    // entries are only used once their seen bit is set
    always_ff @(posedge aclk) begin
        if (accept && cap_trl) begin
            trl_mem[kidx] <= word;
        end
        if (accept && cap_trl && kidx == trl_addr) begin
            trl_q_reg <= word;
        end else begin
            trl_q_reg <= trl_mem[trl_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sfr_status.sv -----
// sfr_status: end-of-record status from length, sector boundary, sector count, array end and tracker error.
// Depends on sfr_pkg (cfg_t, fin_t, error codes).
`default_nettype none

module sfr_status (
    input  sfr_pkg::cfg_t      cfg,
    input  sfr_pkg::fin_t      info,
    output logic [2:0]         status
);
    import sfr_pkg::*;

    logic [ADDR_W-1:0] end_w;
    logic [SCNT_W:0]   want_words;

    // length is a multiple of the sector size when the record ends on a trailer
    always_comb begin
        end_w      = ADDR_W'(cfg.array_offset) + ADDR_W'({cfg.array_words, 1'b0});
        want_words = {1'b0, info.sectors} + 1'b1;
        if (info.rec_len > REC_LIMIT) begin
            status = ERR_CAPACITY;
        end else if (cfg.sec_bytes < 16'd2 || !info.at_boundary) begin
            status = ERR_SIZE;
        end else if ((SCNT_W+1)'(cfg.array_words) != want_words) begin
            status = ERR_COUNT;
        end else if (end_w > ADDR_W'(info.rec_len)) begin
            status = ERR_PAST_END;
        end else begin
            status = info.err;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sector_fixup_restore.sv -----
// sector_fixup_restore: top level; config registers, fixup tracker, status unit, result queue.
// Depends on sfr_pkg, sfr_track, sfr_status, sfr_out_fifo.
//
//   channel   ports                                     moves
//   s_        s_valid/s_ready, s_data_byte, s_last_byte  one raw record byte
//   m_        m_valid/m_ready, m_out_byte,
//             m_end_of_record, m_status                  one restored byte
//   cfg_      cfg_valid/cfg_ready, cfg_index, cfg_data   one register write
//
// One byte per cycle while s_ready is high, with no gap inside or between records.
// A byte's result is queued when the next byte is accepted; the final byte queues
// the held byte and itself at the same edge, and they leave one per cycle while m_ready is high.
// A result queued into an empty queue shows on m_ the cycle after the accepting edge.
// aresetn (synchronous) restores 512/48/3 and clears all record state but the trailer store.
// s_ready falls only while the four-entry queue holds three or more (m_ stall).
`default_nettype none

module sector_fixup_restore (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_end_of_record,
    output logic [2:0]       m_status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import sfr_pkg::*;

    cfg_t        cfg_reg;
    logic        accept;
    logic        trk_push;
    res_t        trk_res;
    logic        fin_valid;
    logic [7:0]  fin_byte;
    fin_t        fin_info;
    logic [2:0]  fin_status;
    res_t        fin_res;
    logic        fifo_room;
    res_t        out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sec_bytes    <= SEC_BYTES_RST;
            cfg_reg.array_offset <= ARRAY_OFFSET_RST;
            cfg_reg.array_words  <= ARRAY_WORDS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SEC_BYTES:    cfg_reg.sec_bytes    <= cfg_data;
                CFG_ARRAY_OFFSET: cfg_reg.array_offset <= cfg_data;
                CFG_ARRAY_WORDS:  cfg_reg.array_words  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ready = fifo_room;
    assign accept  = s_valid && s_ready;

    sfr_track u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .accept     (accept),
        .in_byte    (s_data_byte),
        .in_last    (s_last_byte),
        .push_valid (trk_push),
        .push_res   (trk_res),
        .fin_valid  (fin_valid),
        .fin_byte   (fin_byte),
        .fin_info   (fin_info)
    );

    sfr_status u_status (
        .cfg    (cfg_reg),
        .info   (fin_info),
        .status (fin_status)
    );

    assign fin_res = '{out_byte: fin_byte, end_of_record: 1'b1, status: fin_status};

    // held byte goes ahead of the final byte when both arrive together
    sfr_out_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push0      (trk_push),
        .push0_data (trk_res),
        .push1      (fin_valid),
        .push1_data (fin_res),
        .room       (fifo_room),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_data)
    );

    assign m_out_byte      = out_data.out_byte;
    assign m_end_of_record = out_data.end_of_record;
    assign m_status        = out_data.status;

    a_status_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_end_of_record) |-> (m_status == ERR_NONE))
        else $error("status on a non-final item");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (trk_push || fin_valid) |-> fifo_room)
        else $error("result queue overflow");

    a_valid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");

    a_payload_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_out_byte) && $stable(m_end_of_record)
                                   && $stable(m_status)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire
